@@ rtl/core/tsdr_pkg.sv @@
// Package for the text screen diff refresher: payload structs, operation and
// character codes, controller/datapath interface structs and the escape builder.
// No dependencies.
`default_nettype none

package tsdr_pkg;

   // Grid geometry.
   localparam int MAX_COLUMNS = 128;
   localparam int MAX_LINES   = 64;
   localparam int COL_W       = 7;
   localparam int ROW_W       = 6;
   localparam int ADDR_W      = COL_W + ROW_W;

   // Operation codes.
   localparam logic [2:0] OP_PUT_CHAR     = 3'd0;
   localparam logic [2:0] OP_MOVE         = 3'd1;
   localparam logic [2:0] OP_CLEAR        = 3'd2;
   localparam logic [2:0] OP_CLEAR_BOTTOM = 3'd3;
   localparam logic [2:0] OP_REFRESH      = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_COLUMNS = 2'd0;
   localparam logic [1:0] CSR_LINES   = 2'd1;

   // Character codes.
   localparam logic [7:0] CHAR_TAB     = 8'd9;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_ESC     = 8'h1b;
   localparam logic [7:0] CHAR_BRACKET = 8'h5b;
   localparam logic [7:0] CHAR_SEMI    = 8'h3b;
   localparam logic [7:0] CHAR_H       = 8'h48;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [3:0] TAB_STOP     = 4'd8;

   // Longest byte sequence that the message builder can pack.
   localparam int MSG_BYTES = 11;
   localparam int MSG_IDX_W = 4;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] char_code;
      logic [5:0] target_row;
      logic [6:0] target_column;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_item;
      logic       refresh_done;
   } rsp_type;

   // Strobes from the controller, one per active state.
   typedef struct packed {
      logic latch;
      logic exec;
      logic fill;
      logic eval;
      logic init;
      logic send;
   } cmd_type;

   // Conditions reported back by the datapath.
   typedef struct packed {
      logic [2:0] op;
      logic       closing;
      logic       diff;
      logic       fill_last;
      logic       init_last;
      logic       send_last;
   } status_type;

   typedef struct packed {
      logic [MSG_BYTES-1:0][7:0] bytes;
      logic [MSG_IDX_W-1:0]      count;
   } msg_type;

   typedef struct packed {
      logic       ge100;
      logic       ge10;
      logic [3:0] hundreds;
      logic [3:0] tens;
      logic [3:0] units;
   } dec_type;

   // Decimal digits of an 8-bit value; tens come from a reciprocal multiply.
   function automatic dec_type dec_digits(input logic [7:0] v);
      dec_type     d;
      logic [7:0]  r;
      logic [14:0] p;
      logic [7:0]  t10;
      if (v >= 8'd200) begin
         d.hundreds = 4'd2;
         r = v - 8'd200;
      end else if (v >= 8'd100) begin
         d.hundreds = 4'd1;
         r = v - 8'd100;
      end else begin
         d.hundreds = 4'd0;
         r = v;
      end
      p = {7'd0, r} * 15'd205;
      d.tens = p[14:11];
      t10 = {4'd0, d.tens} * 8'd10;
      d.units = 4'(r - t10);
      d.ge100 = (v >= 8'd100);
      d.ge10 = (v >= 8'd10);
      return d;
   endfunction

   // Packs an optional cursor escape and an optional data byte, in order.
   function automatic msg_type build_msg(input logic has_esc, input logic [7:0] row_v,
                                         input logic [7:0] col_v, input logic has_data,
                                         input logic [7:0] data_byte);
      msg_type                   m;
      dec_type                   rd;
      dec_type                   cd;
      logic [MSG_BYTES-1:0][7:0] cand;
      logic [MSG_BYTES-1:0]      en;
      rd = dec_digits(row_v);
      cd = dec_digits(col_v);
      cand[0]  = CHAR_ESC;                        en[0]  = has_esc;
      cand[1]  = CHAR_BRACKET;                    en[1]  = has_esc;
      cand[2]  = CHAR_ZERO + {4'd0, rd.hundreds}; en[2]  = has_esc & rd.ge100;
      cand[3]  = CHAR_ZERO + {4'd0, rd.tens};     en[3]  = has_esc & rd.ge10;
      cand[4]  = CHAR_ZERO + {4'd0, rd.units};    en[4]  = has_esc;
      cand[5]  = CHAR_SEMI;                       en[5]  = has_esc;
      cand[6]  = CHAR_ZERO + {4'd0, cd.hundreds}; en[6]  = has_esc & cd.ge100;
      cand[7]  = CHAR_ZERO + {4'd0, cd.tens};     en[7]  = has_esc & cd.ge10;
      cand[8]  = CHAR_ZERO + {4'd0, cd.units};    en[8]  = has_esc;
      cand[9]  = CHAR_H;                          en[9]  = has_esc;
      cand[10] = data_byte;                       en[10] = has_data;
      m.bytes = '0;
      m.count = '0;
      for (int i = 0; i < MSG_BYTES; i++) begin
         if (en[i]) begin
            m.bytes[m.count] = cand[i];
            m.count = m.count + 4'd1;
         end
      end
      return m;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/tsdr_ctrl.sv @@
// Controller state machine of the text screen diff refresher.
// Depends on tsdr_pkg for the command and status structs and operation codes.
`default_nettype none

module tsdr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire tsdr_pkg::status_type status,
   output tsdr_pkg::cmd_type         cmd
);

   localparam logic [2:0] ST_INIT = 3'd0;
   localparam logic [2:0] ST_IDLE = 3'd1;
   localparam logic [2:0] ST_EXEC = 3'd2;
   localparam logic [2:0] ST_FILL = 3'd3;
   localparam logic [2:0] ST_READ = 3'd4;
   localparam logic [2:0] ST_EVAL = 3'd5;
   localparam logic [2:0] ST_SEND = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Only the idle state takes a transaction.
   assign req_stall = (state_ff != ST_IDLE);

   // One strobe per active state.
   always_comb begin
      cmd.latch = (state_ff == ST_IDLE) && req_valid;
      cmd.exec  = (state_ff == ST_EXEC);
      cmd.fill  = (state_ff == ST_FILL);
      cmd.eval  = (state_ff == ST_EVAL);
      cmd.init  = (state_ff == ST_INIT);
      cmd.send  = (state_ff == ST_SEND);
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (status.init_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (status.op)
               tsdr_pkg::OP_PUT_CHAR,
               tsdr_pkg::OP_CLEAR,
               tsdr_pkg::OP_CLEAR_BOTTOM: state_in = ST_FILL;
               tsdr_pkg::OP_REFRESH:      state_in = status.closing ? ST_SEND : ST_READ;
               default:                   state_in = ST_IDLE;
            endcase
         end
         ST_FILL: begin
            if (status.fill_last) state_in = ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = status.diff ? ST_SEND : ST_IDLE;
         end
         ST_SEND: begin
            if (status.send_last) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/core/tsdr_datapath.sv @@
// Datapath of the text screen diff refresher: grids, cursor, scan walker,
// fill walker, byte sequencer and configuration registers. Depends on tsdr_pkg.
`default_nettype none

module tsdr_datapath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tsdr_pkg::cmd_type     cmd,
   output tsdr_pkg::status_type       status,
   input  wire tsdr_pkg::req_type     req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output tsdr_pkg::rsp_type          rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [1:0]            csr_index,
   input  wire logic [7:0]            csr_data
);

   // Grid memories.
   logic [7:0] back_mem  [2**tsdr_pkg::ADDR_W];
   logic [7:0] front_mem [2**tsdr_pkg::ADDR_W];
   logic [7:0] back_rd_ff;
   logic [7:0] front_rd_ff;

   // Configuration.
   logic [7:0] cols_ff;
   logic [6:0] lines_ff;

   // Latched request.
   logic [2:0] op_ff;
   logic [7:0] ch_ff;
   logic [5:0] trow_ff;
   logic [6:0] tcol_ff;

   // Control state and next values.
   logic [6:0] cur_col_ff, cur_col_in;
   logic [5:0] cur_row_ff, cur_row_in;
   logic       pending_ff, pending_in;
   logic [6:0] scan_col_ff, scan_col_in;
   logic [6:0] scan_row_ff, scan_row_in;
   logic [6:0] emit_col_ff, emit_col_in;
   logic [6:0] emit_row_ff, emit_row_in;
   logic       emit_valid_ff, emit_valid_in;
   logic [6:0] fill_col_ff, fill_col_in;
   logic [5:0] fill_row_ff, fill_row_in;
   logic [7:0] fill_end_ff, fill_end_in;
   logic [5:0] fill_lrow_ff, fill_lrow_in;
   logic [7:0] fill_byte_ff, fill_byte_in;
   logic [tsdr_pkg::ADDR_W-1:0] init_addr_ff, init_addr_in;
   tsdr_pkg::msg_type           msg_ff, msg_in;
   logic                        done_ff, done_in;
   logic [tsdr_pkg::MSG_IDX_W-1:0] send_idx_ff, send_idx_in;

   // Effective geometry and derived values.
   logic [7:0] ec, ec_m1;
   logic [6:0] el, el_m1;
   logic [6:0] sat_col, move_col;
   logic [5:0] sat_row, move_row;
   logic       cur_last_row;
   logic [3:0] tab_len;
   logic [7:0] tab_sum, tab_end;
   logic       adj_wrap;
   logic [6:0] adj_col, adj_row;
   logic       closing;
   logic [7:0] scan_next;
   logic       contig;
   logic       diff;
   logic       fill_last;
   logic       send_last;
   logic [tsdr_pkg::ADDR_W-1:0] rd_addr;

   // Register values out of range act as the nearest legal value.
   always_comb begin
      if (cols_ff == 8'd0) ec = 8'd1;
      else if (cols_ff > 8'(tsdr_pkg::MAX_COLUMNS)) ec = 8'(tsdr_pkg::MAX_COLUMNS);
      else ec = cols_ff;
      if (lines_ff == 7'd0) el = 7'd1;
      else if (lines_ff > 7'(tsdr_pkg::MAX_LINES)) el = 7'(tsdr_pkg::MAX_LINES);
      else el = lines_ff;
   end
   assign ec_m1 = ec - 8'd1;
   assign el_m1 = el - 7'd1;

   // Cursor and move target saturated to the grid in use.
   assign sat_col  = ({1'b0, cur_col_ff} >= ec) ? ec_m1[6:0] : cur_col_ff;
   assign sat_row  = ({1'b0, cur_row_ff} >= el) ? el_m1[5:0] : cur_row_ff;
   assign move_col = ({1'b0, tcol_ff} >= ec) ? ec_m1[6:0] : tcol_ff;
   assign move_row = ({1'b0, trow_ff} >= el) ? el_m1[5:0] : trow_ff;
   assign cur_last_row = ({1'b0, cur_row_ff} == el_m1);

   // Tab span, clipped at the row end.
   assign tab_len = tsdr_pkg::TAB_STOP - {1'b0, cur_col_ff[2:0]};
   assign tab_sum = {1'b0, cur_col_ff} + {4'd0, tab_len};
   assign tab_end = (tab_sum > ec) ? ec : tab_sum;

   // Scan position after the wrap of a column beyond the row.
   assign adj_wrap = ({1'b0, scan_col_ff} >= ec);
   assign adj_col  = adj_wrap ? 7'd0 : scan_col_ff;
   assign adj_row  = adj_wrap ? scan_row_ff + 7'd1 : scan_row_ff;
   assign closing  = !pending_ff || (adj_row >= el);

   // Cell comparison.
   assign scan_next = {1'b0, scan_col_ff} + 8'd1;
   assign contig = emit_valid_ff && (emit_col_ff == scan_col_ff) && (emit_row_ff == scan_row_ff);
   assign diff = (back_rd_ff != front_rd_ff);

   assign fill_last = ({1'b0, fill_col_ff} + 8'd1 == fill_end_ff) &&
                      (fill_row_ff == fill_lrow_ff);
   assign send_last = cmd.send && !rsp_stall && (send_idx_ff == msg_ff.count - 4'd1);

   assign rd_addr = {scan_row_ff[5:0], scan_col_ff};

   always_comb begin
      status.op        = op_ff;
      status.closing   = closing;
      status.diff      = diff;
      status.fill_last = fill_last;
      status.init_last = (init_addr_ff == {tsdr_pkg::ADDR_W{1'b1}});
      status.send_last = send_last;
   end

   // Next-state logic of the datapath.
   always_comb begin
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      pending_in    = pending_ff;
      scan_col_in   = scan_col_ff;
      scan_row_in   = scan_row_ff;
      emit_col_in   = emit_col_ff;
      emit_row_in   = emit_row_ff;
      emit_valid_in = emit_valid_ff;
      fill_col_in   = fill_col_ff;
      fill_row_in   = fill_row_ff;
      fill_end_in   = fill_end_ff;
      fill_lrow_in  = fill_lrow_ff;
      fill_byte_in  = fill_byte_ff;
      init_addr_in  = init_addr_ff;
      msg_in        = msg_ff;
      done_in       = done_ff;
      send_idx_in   = send_idx_ff;

      if (cmd.latch) begin
         cur_col_in = sat_col;
         cur_row_in = sat_row;
      end

      if (cmd.exec) begin
         case (op_ff)
            tsdr_pkg::OP_PUT_CHAR: begin
               pending_in    = 1'b1;
               scan_col_in   = 7'd0;
               scan_row_in   = 7'd0;
               emit_valid_in = 1'b0;
               fill_col_in   = cur_col_ff;
               fill_row_in   = cur_row_ff;
               fill_lrow_in  = cur_row_ff;
               if (ch_ff == tsdr_pkg::CHAR_NEWLINE) begin
                  fill_end_in  = ec;
                  fill_byte_in = 8'd0;
                  if (!cur_last_row) begin
                     cur_col_in = 7'd0;
                     cur_row_in = cur_row_ff + 6'd1;
                  end
               end else if (ch_ff == tsdr_pkg::CHAR_TAB) begin
                  fill_end_in  = tab_end;
                  fill_byte_in = tsdr_pkg::CHAR_SPACE;
                  if (tab_end >= ec) begin
                     if (!cur_last_row) begin
                        cur_col_in = 7'd0;
                        cur_row_in = cur_row_ff + 6'd1;
                     end else begin
                        cur_col_in = ec_m1[6:0];
                     end
                  end else begin
                     cur_col_in = tab_end[6:0];
                  end
               end else begin
                  fill_end_in  = {1'b0, cur_col_ff} + 8'd1;
                  fill_byte_in = ch_ff;
                  if ({1'b0, cur_col_ff} == ec_m1) begin
                     if (!cur_last_row) begin
                        cur_col_in = 7'd0;
                        cur_row_in = cur_row_ff + 6'd1;
                     end
                  end else begin
                     cur_col_in = cur_col_ff + 7'd1;
                  end
               end
            end
            tsdr_pkg::OP_MOVE: begin
               cur_col_in = move_col;
               cur_row_in = move_row;
            end
            tsdr_pkg::OP_CLEAR,
            tsdr_pkg::OP_CLEAR_BOTTOM: begin
               pending_in    = 1'b1;
               scan_col_in   = 7'd0;
               scan_row_in   = 7'd0;
               emit_valid_in = 1'b0;
               fill_end_in   = ec;
               fill_lrow_in  = el_m1[5:0];
               fill_byte_in  = 8'd0;
               if (op_ff == tsdr_pkg::OP_CLEAR) begin
                  fill_col_in = 7'd0;
                  fill_row_in = 6'd0;
               end else begin
                  fill_col_in = cur_col_ff;
                  fill_row_in = cur_row_ff;
               end
            end
            tsdr_pkg::OP_REFRESH: begin
               if (closing) begin
                  msg_in = tsdr_pkg::build_msg(1'b1, {2'd0, cur_row_ff} + 8'd1,
                                               {1'b0, cur_col_ff} + 8'd1, 1'b0, 8'd0);
                  done_in       = 1'b1;
                  send_idx_in   = '0;
                  pending_in    = 1'b0;
                  scan_col_in   = 7'd0;
                  scan_row_in   = 7'd0;
                  emit_valid_in = 1'b0;
               end else begin
                  scan_col_in = adj_col;
                  scan_row_in = adj_row;
               end
            end
            default: begin
            end
         endcase
      end

      // Fill walker: one cell per cycle, wrapping to column zero of the next row.
      if (cmd.fill) begin
         if ({1'b0, fill_col_ff} + 8'd1 == fill_end_ff) begin
            fill_col_in = 7'd0;
            fill_row_in = fill_row_ff + 6'd1;
         end else begin
            fill_col_in = fill_col_ff + 7'd1;
         end
      end

      // Cell examination.
      if (cmd.eval) begin
         if (diff || back_rd_ff != 8'd0) begin
            if (scan_next == ec) begin
               scan_col_in = 7'd0;
               scan_row_in = scan_row_ff + 7'd1;
            end else begin
               scan_col_in = scan_next[6:0];
            end
         end else begin
            scan_col_in = 7'd0;
            scan_row_in = scan_row_ff + 7'd1;
         end
         if (diff) begin
            msg_in = tsdr_pkg::build_msg(!contig, {1'b0, scan_row_ff} + 8'd1,
                                         scan_next, 1'b1, back_rd_ff);
            done_in       = 1'b0;
            send_idx_in   = '0;
            emit_col_in   = scan_col_in;
            emit_row_in   = scan_row_in;
            emit_valid_in = 1'b1;
         end
      end

      if (cmd.init) init_addr_in = init_addr_ff + 1'b1;

      // Byte sequencer advances on each output transaction.
      if (cmd.send && !rsp_stall) begin
         send_idx_in = send_last ? '0 : send_idx_ff + 4'd1;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff       <= 8'd80;
         lines_ff      <= 7'd25;
         cur_col_ff    <= '0;
         cur_row_ff    <= '0;
         pending_ff    <= 1'b0;
         scan_col_ff   <= '0;
         scan_row_ff   <= '0;
         emit_col_ff   <= '0;
         emit_row_ff   <= '0;
         emit_valid_ff <= 1'b0;
         init_addr_ff  <= '0;
         send_idx_ff   <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == tsdr_pkg::CSR_COLUMNS) cols_ff <= csr_data;
            else if (csr_index == tsdr_pkg::CSR_LINES) lines_ff <= csr_data[6:0];
         end
         cur_col_ff    <= cur_col_in;
         cur_row_ff    <= cur_row_in;
         pending_ff    <= pending_in;
         scan_col_ff   <= scan_col_in;
         scan_row_ff   <= scan_row_in;
         emit_col_ff   <= emit_col_in;
         emit_row_ff   <= emit_row_in;
         emit_valid_ff <= emit_valid_in;
         init_addr_ff  <= init_addr_in;
         send_idx_ff   <= send_idx_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= req_data.operation;
         ch_ff   <= req_data.char_code;
         trow_ff <= req_data.target_row;
         tcol_ff <= req_data.target_column;
      end
      fill_col_ff  <= fill_col_in;
      fill_row_ff  <= fill_row_in;
      fill_end_ff  <= fill_end_in;
      fill_lrow_ff <= fill_lrow_in;
      fill_byte_ff <= fill_byte_in;
      msg_ff       <= msg_in;
      done_ff      <= done_in;
   end

   // Back grid: written by the clearing pass and the fill walker.
   always_ff @(posedge clock) begin
      if (cmd.init) back_mem[init_addr_ff] <= 8'd0;
      else if (cmd.fill) back_mem[{fill_row_ff, fill_col_ff}] <= fill_byte_ff;
      back_rd_ff <= back_mem[rd_addr];
   end

   // Front grid: written by the clearing pass and by each sent cell.
   always_ff @(posedge clock) begin
      if (cmd.init) front_mem[init_addr_ff] <= 8'd0;
      else if (cmd.eval && diff) front_mem[rd_addr] <= back_rd_ff;
      front_rd_ff <= front_mem[rd_addr];
   end

   // Output channel.
   assign csr_ready = 1'b1;
   assign rsp_valid = cmd.send;
   always_comb begin
      rsp_data.out_byte     = msg_ff.bytes[send_idx_ff];
      rsp_data.last_of_item = (send_idx_ff == msg_ff.count - 4'd1);
      rsp_data.refresh_done = done_ff && (send_idx_ff == msg_ff.count - 4'd1);
   end

endmodule

`default_nettype wire

@@ rtl/core/text_screen_diff_refresher.sv @@
// Text screen diff refresher: a back and a front character grid and a cursor
// updated by put_char, move and clear, and sent to a terminal by refresh_step.
// Channels: req_ (one operation per transaction, valid/stall), rsp_ (one output
// byte per transaction, valid/stall), csr_ (register writes, valid/ready).
// After reset a clearing pass zeroes both grids; req_stall is high during it,
// while register writes are taken at any time. One operation is worked on at a
// time; move and ignored codes end in the execute state. put_char and the clears
// write one cell per cycle, from one cell up to the whole grid in use, through
// the single back grid write port. A refresh_step reads and compares one cell
// (execute, read, eval states) and, if it differs, sends up to 10 bytes, one per
// cycle while rsp_stall is low; with no cell left to scan it sends only the
// closing cursor escape. While rsp_stall is high the current byte holds and no
// new operation starts. Depends on tsdr_pkg, tsdr_ctrl and tsdr_datapath.
`default_nettype none

module text_screen_diff_refresher (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire tsdr_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output tsdr_pkg::rsp_type      rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [1:0]        csr_index,
   input  wire logic [7:0]        csr_data
);

   tsdr_pkg::cmd_type    cmd;
   tsdr_pkg::status_type status;

   // Sequencing.
   tsdr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Grids, walkers and byte output.
   tsdr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

endmodule

`default_nettype wire
